[rtl/bmprle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BMP RLE8 decoder package
// Shared widths, request and register codes, decode phase type.
// ----------------------------------------------------------------------------
package bmprle_pkg;

   localparam int POS_W      = 11;
   localparam int OFS_W      = 22;
   localparam int BYTE_W     = 8;
   localparam int RGB_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_TYPE_W = 2;

   localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int MAX_HEIGHT_DEF    = 1024;
   localparam int PALETTE_DEPTH_DEF = 256;

   localparam logic [REQ_TYPE_W-1:0] REQ_PALETTE = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DATA    = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
   localparam logic [BYTE_W-1:0] ESC_EOP   = 8'd1;
   localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

   typedef enum logic [6:0] {
      PH_COUNT  = 7'b0000001,
      PH_SECOND = 7'b0000010,
      PH_DX     = 7'b0000100,
      PH_DY     = 7'b0001000,
      PH_LIT    = 7'b0010000,
      PH_PAD    = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   // saturating position add
   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[POS_W] ? POS_MAX : s[POS_W-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/bmprle_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BMP RLE8 decoder channels
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmprle_req_if;
   logic                             valid;
   logic                             ready;
   logic [bmprle_pkg::REQ_TYPE_W-1:0] req_type;
   logic [bmprle_pkg::BYTE_W-1:0]     data_byte;
   logic [bmprle_pkg::BYTE_W-1:0]     palette_index;
   logic [bmprle_pkg::BYTE_W-1:0]     palette_red;
   logic [bmprle_pkg::BYTE_W-1:0]     palette_green;
   logic [bmprle_pkg::BYTE_W-1:0]     palette_blue;

   modport source (output valid, req_type, data_byte, palette_index, palette_red,
                   palette_green, palette_blue, input ready);
   modport sink (input valid, req_type, data_byte, palette_index, palette_red,
                 palette_green, palette_blue, output ready);
endinterface

interface bmprle_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bmprle_pkg::OFS_W-1:0]  write_start;
   logic [bmprle_pkg::BYTE_W-1:0] write_length;
   logic [bmprle_pkg::BYTE_W-1:0] red;
   logic [bmprle_pkg::BYTE_W-1:0] green;
   logic [bmprle_pkg::BYTE_W-1:0] blue;
   logic                         picture_done;
   logic                         range_error;

   modport source (output valid, write_start, write_length, red, green, blue,
                   picture_done, range_error, input ready);
   modport sink (input valid, write_start, write_length, red, green, blue,
                 picture_done, range_error, output ready);
endinterface

interface bmprle_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bmprle_pkg::CSR_IDX_W-1:0] reg_index;
   logic [bmprle_pkg::POS_W-1:0]     write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface
`default_nettype wire

[rtl/bmp_rle8_pixel_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BMP RLE8 pixel decoder
// Turns an RLE8 byte stream into frame-buffer fill requests, colour from a
// loaded palette memory.
// ----------------------------------------------------------------------------
//  channel   dir  carries
//  req_bus   in   palette write, stream byte or picture restart
//  rsp_bus   out  fill request: offset, length, RGB, done, range error
//  csr_bus   in   image_width (0), image_height (1)
//
//  One request per cycle while req_bus.ready is high; a fill passes through stage 1 and the output register.
//  Palette is a 1R1W memory, read registered on the accepting edge.
//  Reset clears decode state and sets both sizes to 1; palette is undefined until loaded.
//  A stalled response holds one fill in stage 1 and one in the output
//  register before req_bus.ready drops.
// ----------------------------------------------------------------------------
module bmp_rle8_pixel_decoder #(
   parameter int MAX_WIDTH     = bmprle_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = bmprle_pkg::MAX_HEIGHT_DEF,
   parameter int PALETTE_DEPTH = bmprle_pkg::PALETTE_DEPTH_DEF
) (
   input  wire          clock,
   input  wire          reset,
   bmprle_req_if.sink   req_bus,
   bmprle_rsp_if.source rsp_bus,
   bmprle_csr_if.sink   csr_bus
);

   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int PW     = bmprle_pkg::POS_W;
   localparam int OW     = bmprle_pkg::OFS_W;
   localparam int BW     = bmprle_pkg::BYTE_W;

   // configuration
   logic [PW-1:0] width_ff, width_in, height_ff, height_in;
   logic [PW-1:0] eff_w, eff_h;

   // decode state
   bmprle_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0] held_ff, held_in, lit_ff, lit_in, dright_ff, dright_in;
   logic          pad_ff, pad_in;
   logic [PW-1:0] col_ff, col_in, row_ff, row_in;
   logic [BW-1:0] lit_dec;

   // stage 1
   logic          s1_v_ff, s1_v_in;
   logic [OW-1:0] s1_start_ff, s1_start_in;
   logic [BW-1:0] s1_len_ff, s1_len_in;
   logic          s1_done_ff, s1_done_in;
   logic          s1_oor_ff;
   logic [bmprle_pkg::RGB_W-1:0] pal_q_ff;

   // output register
   logic          out_v_ff, out_v_in;
   logic [OW-1:0] out_start_ff;
   logic [BW-1:0] out_len_ff, out_r_ff, out_g_ff, out_b_ff;
   logic          out_done_ff, out_err_ff;

   logic [bmprle_pkg::RGB_W-1:0] pal_mem [PALETTE_DEPTH];

   logic          accept, emit, out_ld, s1_adv, pal_we;
   logic [OW-1:0] row_ofs, limit;
   logic          err;
   logic [BW-1:0] b;

   assign out_ld        = !out_v_ff || rsp_bus.ready;
   assign s1_adv        = s1_v_ff && out_ld;
   assign req_bus.ready = !s1_v_ff || out_ld;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign b             = req_bus.data_byte;

   assign eff_w = (width_ff > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : width_ff;
   assign eff_h = (height_ff > PW'(MAX_HEIGHT)) ? PW'(MAX_HEIGHT) : height_ff;
   assign row_ofs = OW'(row_ff) * OW'(eff_w);
   assign limit   = OW'(eff_w) * OW'(eff_h);
   assign lit_dec = lit_ff - BW'(1);
   assign pal_we  = accept && (req_bus.req_type == bmprle_pkg::REQ_PALETTE)
                    && ({1'b0, req_bus.palette_index} < (BW+1)'(PALETTE_DEPTH));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            bmprle_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_bus.write_data;
            bmprle_pkg::CSR_IMAGE_HEIGHT: height_in = csr_bus.write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      lit_in      = lit_ff;
      pad_in      = pad_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      dright_in   = dright_ff;
      emit        = 1'b0;
      s1_len_in   = s1_len_ff;
      s1_done_in  = s1_done_ff;
      s1_start_in = OW'(col_ff) + row_ofs;
      if (accept && req_bus.req_type == bmprle_pkg::REQ_START) begin
         phase_in  = bmprle_pkg::PH_COUNT;
         held_in   = '0;
         lit_in    = '0;
         pad_in    = 1'b0;
         col_in    = '0;
         row_in    = '0;
         dright_in = '0;
      end else if (accept && req_bus.req_type == bmprle_pkg::REQ_DATA) begin
         unique case (phase_ff)
            bmprle_pkg::PH_COUNT: begin
               held_in  = b;
               phase_in = bmprle_pkg::PH_SECOND;
            end
            bmprle_pkg::PH_SECOND: begin
               if (held_ff != '0) begin
                  emit       = 1'b1;
                  s1_len_in  = held_ff;
                  s1_done_in = 1'b0;
                  col_in     = bmprle_pkg::sat_add(col_ff, PW'(held_ff));
                  phase_in   = bmprle_pkg::PH_COUNT;
               end else if (b == bmprle_pkg::ESC_EOL) begin
                  col_in   = '0;
                  row_in   = bmprle_pkg::sat_add(row_ff, PW'(1));
                  phase_in = bmprle_pkg::PH_COUNT;
               end else if (b == bmprle_pkg::ESC_EOP) begin
                  emit       = 1'b1;
                  s1_len_in  = '0;
                  s1_done_in = 1'b1;
                  phase_in   = bmprle_pkg::PH_DONE;
               end else if (b == bmprle_pkg::ESC_DELTA) begin
                  phase_in = bmprle_pkg::PH_DX;
               end else begin
                  lit_in   = b;
                  pad_in   = b[0];
                  phase_in = bmprle_pkg::PH_LIT;
               end
            end
            bmprle_pkg::PH_DX: begin
               dright_in = b;
               phase_in  = bmprle_pkg::PH_DY;
            end
            bmprle_pkg::PH_DY: begin
               col_in   = bmprle_pkg::sat_add(col_ff, PW'(dright_ff));
               row_in   = bmprle_pkg::sat_add(row_ff, PW'(b));
               phase_in = bmprle_pkg::PH_COUNT;
            end
            bmprle_pkg::PH_LIT: begin
               emit       = 1'b1;
               s1_len_in  = BW'(1);
               s1_done_in = 1'b0;
               col_in     = bmprle_pkg::sat_add(col_ff, PW'(1));
               lit_in     = lit_dec;
               if (lit_dec == '0) begin
                  phase_in = pad_ff ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
               end
            end
            bmprle_pkg::PH_PAD: begin
               pad_in   = 1'b0;
               phase_in = bmprle_pkg::PH_COUNT;
            end
            bmprle_pkg::PH_DONE: ;
            default: ;
         endcase
      end
   end

   assign s1_v_in  = emit ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
   assign out_v_in = s1_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_v_ff);
   assign err = (({1'b0, s1_start_ff} + (OW+1)'(s1_len_ff)) > {1'b0, limit});

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PW'(1);
         height_ff <= PW'(1);
         phase_ff  <= bmprle_pkg::PH_COUNT;
         held_ff   <= '0;
         lit_ff    <= '0;
         pad_ff    <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         dright_ff <= '0;
         s1_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         lit_ff    <= lit_in;
         pad_ff    <= pad_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         dright_ff <= dright_in;
         s1_v_ff   <= s1_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // palette memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[req_bus.palette_index[PAL_AW-1:0]] <=
            {req_bus.palette_red, req_bus.palette_green, req_bus.palette_blue};
      end
      if (emit) begin
         pal_q_ff <= pal_mem[b[PAL_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_start_ff <= s1_start_in;
         s1_len_ff   <= s1_len_in;
         s1_done_ff  <= s1_done_in;
         s1_oor_ff   <= ({1'b0, b} >= (BW+1)'(PALETTE_DEPTH));
      end
      if (s1_adv) begin
         if (s1_done_ff) begin
            out_start_ff <= '0;
            out_len_ff   <= '0;
            out_r_ff     <= '0;
            out_g_ff     <= '0;
            out_b_ff     <= '0;
            out_done_ff  <= 1'b1;
            out_err_ff   <= 1'b0;
         end else begin
            out_start_ff <= s1_start_ff;
            out_len_ff   <= s1_len_ff;
            out_r_ff     <= (err || s1_oor_ff) ? '0 : pal_q_ff[23:16];
            out_g_ff     <= (err || s1_oor_ff) ? '0 : pal_q_ff[15:8];
            out_b_ff     <= (err || s1_oor_ff) ? '0 : pal_q_ff[7:0];
            out_done_ff  <= 1'b0;
            out_err_ff   <= err;
         end
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.write_start  = out_start_ff;
   assign rsp_bus.write_length = out_len_ff;
   assign rsp_bus.red          = out_r_ff;
   assign rsp_bus.green        = out_g_ff;
   assign rsp_bus.blue         = out_b_ff;
   assign rsp_bus.picture_done = out_done_ff;
   assign rsp_bus.range_error  = out_err_ff;

   a_stall_holds_s1: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && out_v_ff && !rsp_bus.ready |=> s1_v_ff)
      else $error("stage 1 dropped a fill under stall");

   a_ready_low_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> s1_v_ff && out_v_ff && !rsp_bus.ready)
      else $error("request stalled with room in the pipe");

   a_done_is_empty: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_done_ff |-> out_len_ff == '0 && !out_err_ff)
      else $error("done response carries a fill");

   a_done_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == bmprle_pkg::PH_DONE && !(accept &&
      req_bus.req_type == bmprle_pkg::REQ_START) |=> phase_ff == bmprle_pkg::PH_DONE)
      else $error("left done phase without restart");

   a_err_no_colour: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_err_ff |-> {out_r_ff, out_g_ff, out_b_ff} == '0)
      else $error("colour on a range error");

endmodule
`default_nettype wire

[tb/bmprle_fill_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE8 decoder fill checker
// Watches the request, response and register channels, decodes every
// accepted request into the fill it should produce and compares each
// response with the oldest outstanding fill.
// ----------------------------------------------------------------------------
module bmprle_fill_checker #(
   parameter int MAX_WIDTH     = bmprle_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = bmprle_pkg::MAX_HEIGHT_DEF,
   parameter int PALETTE_DEPTH = bmprle_pkg::PALETTE_DEPTH_DEF
) (
   input  wire   clock,
   input  wire   reset,
   bmprle_req_if req_bus,
   bmprle_rsp_if rsp_bus,
   bmprle_csr_if csr_bus,
   output int    fail_count,
   output int    pending_count,
   output int    fill_count,
   output int    error_count,
   output int    done_count
);
   import bmprle_pkg::*;

   typedef struct packed {
      logic [OFS_W-1:0]  write_start;
      logic [BYTE_W-1:0] write_length;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic              picture_done;
      logic              range_error;
   } fill_t;

   fill_t             expected_fills[$];
   phase_type         phase_now;
   logic [BYTE_W-1:0] run_count;
   logic [BYTE_W-1:0] lits_left;
   logic [BYTE_W-1:0] skip_right;
   logic              pad_due;
   logic [POS_W-1:0]  col_pos;
   logic [POS_W-1:0]  row_pos;
   logic [POS_W-1:0]  width_reg;
   logic [POS_W-1:0]  height_reg;
   logic [RGB_W-1:0]  colour_table [PALETTE_DEPTH];

   function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] p,
                                                input int unsigned d);
      int unsigned s;
      s = p + d;
      return (s > POS_MAX) ? POS_MAX : s[POS_W-1:0];
   endfunction

   task automatic restart_picture();
      phase_now  = PH_COUNT;
      run_count  = '0;
      lits_left  = '0;
      skip_right = '0;
      pad_due    = 1'b0;
      col_pos    = '0;
      row_pos    = '0;
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (fail_count < 40)
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // fill at the current position; out of range fills carry no colour
   task automatic push_fill(input logic [BYTE_W-1:0] len,
                            input logic [BYTE_W-1:0] colour_idx);
      fill_t            f;
      int unsigned      w;
      int unsigned      h;
      int unsigned      ofs;
      logic [RGB_W-1:0] rgb;
      w   = (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h   = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
      ofs = col_pos + row_pos * w;
      rgb = (colour_idx < PALETTE_DEPTH) ? colour_table[colour_idx] : '0;
      f = '0;
      f.write_start  = ofs[OFS_W-1:0];
      f.write_length = len;
      f.range_error  = (ofs + len) > (w * h);
      if (!f.range_error)
         {f.red, f.green, f.blue} = rgb;
      expected_fills.push_back(f);
   endtask

   task automatic decode_request(input logic [REQ_TYPE_W-1:0] kind,
                                 input logic [BYTE_W-1:0] value,
                                 input logic [BYTE_W-1:0] idx,
                                 input logic [BYTE_W-1:0] r,
                                 input logic [BYTE_W-1:0] g,
                                 input logic [BYTE_W-1:0] b);
      fill_t f;
      case (kind)
         REQ_PALETTE: begin
            if (idx < PALETTE_DEPTH)
               colour_table[idx] = {r, g, b};
         end
         REQ_START: begin
            restart_picture();
         end
         REQ_DATA: begin
            case (phase_now)
               PH_COUNT: begin
                  run_count = value;
                  phase_now = PH_SECOND;
               end
               PH_SECOND: begin
                  if (run_count != 0) begin
                     push_fill(run_count, value);
                     col_pos   = advance(col_pos, run_count);
                     phase_now = PH_COUNT;
                  end else if (value == ESC_EOL) begin
                     col_pos   = '0;
                     row_pos   = advance(row_pos, 1);
                     phase_now = PH_COUNT;
                  end else if (value == ESC_EOP) begin
                     f = '0;
                     f.picture_done = 1'b1;
                     expected_fills.push_back(f);
                     phase_now = PH_DONE;
                  end else if (value == ESC_DELTA) begin
                     phase_now = PH_DX;
                  end else begin
                     lits_left = value;
                     pad_due   = value[0];
                     phase_now = PH_LIT;
                  end
               end
               PH_DX: begin
                  skip_right = value;
                  phase_now  = PH_DY;
               end
               PH_DY: begin
                  col_pos   = advance(col_pos, skip_right);
                  row_pos   = advance(row_pos, value);
                  phase_now = PH_COUNT;
               end
               PH_LIT: begin
                  push_fill(8'd1, value);
                  col_pos   = advance(col_pos, 1);
                  lits_left = lits_left - 8'd1;
                  if (lits_left == 0)
                     phase_now = pad_due ? PH_PAD : PH_COUNT;
               end
               PH_PAD: begin
                  pad_due   = 1'b0;
                  phase_now = PH_COUNT;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic check_fill(input fill_t got);
      fill_t want;
      if (expected_fills.size() == 0) begin
         report_mismatch("fill with no request behind it, offset", got.write_start, 0);
         return;
      end
      want = expected_fills.pop_front();
      if (got.write_start !== want.write_start)
         report_mismatch("write_start", got.write_start, want.write_start);
      if (got.write_length !== want.write_length)
         report_mismatch("write_length", got.write_length, want.write_length);
      if (got.red !== want.red)
         report_mismatch("red", got.red, want.red);
      if (got.green !== want.green)
         report_mismatch("green", got.green, want.green);
      if (got.blue !== want.blue)
         report_mismatch("blue", got.blue, want.blue);
      if (got.picture_done !== want.picture_done)
         report_mismatch("picture_done", got.picture_done, want.picture_done);
      if (got.range_error !== want.range_error)
         report_mismatch("range_error", got.range_error, want.range_error);
      if (want.picture_done)
         done_count++;
      else if (want.range_error)
         error_count++;
      else
         fill_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_picture();
         width_reg  = 11'd1;
         height_reg = 11'd1;
         expected_fills.delete();
         fail_count  = 0;
         fill_count  = 0;
         error_count = 0;
         done_count  = 0;
         pending_count <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_bus.write_data;
               CSR_IMAGE_HEIGHT: height_reg = csr_bus.write_data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready)
            check_fill({rsp_bus.write_start, rsp_bus.write_length, rsp_bus.red,
                        rsp_bus.green, rsp_bus.blue, rsp_bus.picture_done,
                        rsp_bus.range_error});
         if (req_bus.valid && req_bus.ready)
            decode_request(req_bus.req_type, req_bus.data_byte, req_bus.palette_index,
                           req_bus.palette_red, req_bus.palette_green,
                           req_bus.palette_blue);
         pending_count <= expected_fills.size();
      end
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE8 pixel decoder testbench
// Loads the palette, runs a short directed stream, then random RLE8 streams
// under several image sizes with random gaps and stalls on both channels,
// a long response hold-off and a full drain. Checking is in the fill checker.
// ----------------------------------------------------------------------------
module tb_top;
   import bmprle_pkg::*;

   localparam int CLK_PERIOD      = 8;
   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 120;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RANDOM_REQUESTS = 450;
   localparam int PHASES          = 6;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [BYTE_W-1:0]     ESCAPE     = 8'd0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmprle_req_if req_bus ();
   bmprle_rsp_if rsp_bus ();
   bmprle_csr_if csr_bus ();

   int          fail_count;
   int          pending_count;
   int          fill_count;
   int          error_count;
   int          done_count;
   int unsigned requests_sent  = 0;
   int unsigned settings_used  = 0;
   int unsigned quiet_cycles   = 0;
   bit          idle_on        = 1'b1;
   bit          stall_on       = 1'b1;
   bit          long_hold      = 1'b0;
   logic        moved;

   always #(CLK_PERIOD / 2) clock = ~clock;

   bmp_rle8_pixel_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   bmprle_fill_checker u_fill_check (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .fill_count    (fill_count),
      .error_count   (error_count),
      .done_count    (done_count)
   );

   assign moved = (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                  (csr_bus.valid && csr_bus.ready);

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if (moved) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random stalls, one long hold-off on demand
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(0, 9)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input logic [REQ_TYPE_W-1:0] kind,
                               input logic [BYTE_W-1:0] value,
                               input logic [BYTE_W-1:0] idx,
                               input logic [BYTE_W-1:0] r,
                               input logic [BYTE_W-1:0] g,
                               input logic [BYTE_W-1:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= kind;
      req_bus.data_byte     <= value;
      req_bus.palette_index <= idx;
      req_bus.palette_red   <= r;
      req_bus.palette_green <= g;
      req_bus.palette_blue  <= b;
      do @(posedge clock); while (!req_bus.ready);
      if (kind != REQ_UNUSED)
         requests_sent++;
   endtask

   task automatic send_data(input logic [BYTE_W-1:0] value);
      send_request(REQ_DATA, value, 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   task automatic send_start();
      send_request(REQ_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom));
   endtask

   task automatic send_delta(input logic [BYTE_W-1:0] dx, input logic [BYTE_W-1:0] dy);
      send_data(ESCAPE);
      send_data(ESC_DELTA);
      send_data(dx);
      send_data(dy);
   endtask

   // stop offering and let every outstanding fill drain
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [POS_W-1:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic set_size(input logic [POS_W-1:0] w, input logic [POS_W-1:0] h);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // one well-formed RLE8 construct or palette write, or now and then noise, a cut-off one or a restart
   task automatic send_rle_chunk();
      int unsigned pick;
      int unsigned n;
      int unsigned i;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
         send_data(8'(n));
         send_data(8'($urandom));
      end else if (pick < 50) begin
         n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
         send_data(ESCAPE);
         send_data(8'(n));
         for (i = 0; i < n; i++)
            send_data(8'($urandom));
         if (n % 2)
            send_data(8'($urandom));
      end else if (pick < 60) begin
         send_data(ESCAPE);
         send_data(ESC_EOL);
      end else if (pick < 68) begin
         if ($urandom_range(0, 7) == 0)
            send_delta(8'hFF, 8'($urandom));
         else
            send_delta(8'($urandom_range(0, 4)), 8'($urandom_range(0, 2)));
      end else if (pick < 70) begin
         // push both coordinates into saturation, then draw there
         repeat (9) send_delta(8'hFF, 8'hFF);
         send_data(ESCAPE);
         send_data(8'd4);
         repeat (4) send_data(8'($urandom));
      end else if (pick < 76) begin
         send_request(REQ_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
         send_data(ESCAPE);
         send_data(ESC_EOP);
         repeat ($urandom_range(0, 3)) send_data(8'($urandom));
         send_start();
      end else if (pick < 88) begin
         case ($urandom_range(0, 3))
            0: begin
               send_data(ESCAPE);
            end
            1: begin
               send_data(ESCAPE);
               send_data(ESC_DELTA);
               send_data(8'($urandom));
            end
            2: begin
               n = $urandom_range(3, 12);
               send_data(ESCAPE);
               send_data(8'(n));
               repeat ($urandom_range(0, n - 1)) send_data(8'($urandom));
            end
            default: begin
               send_data(8'($urandom_range(1, 255)));
            end
         endcase
         send_start();
      end else if (pick < 95) begin
         send_data(8'($urandom));
      end else if (pick < 98) begin
         send_request(REQ_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
      end else begin
         send_start();
      end
   endtask

   initial begin
      int unsigned p;
      int unsigned i;
      int unsigned target;
      int unsigned mid;
      bit          mid_done;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_DATA;
      req_bus.data_byte     <= '0;
      req_bus.palette_index <= '0;
      req_bus.palette_red   <= '0;
      req_bus.palette_green <= '0;
      req_bus.palette_blue  <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.reg_index     <= CSR_IMAGE_WIDTH;
      csr_bus.write_data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 256; i++)
         send_request(REQ_PALETTE, 8'($urandom), 8'(i), 8'($urandom), 8'($urandom),
                      8'($urandom));

      // directed: 8x2 image, so the second run fills the first row exactly
      set_size(11'd8, 11'd2);
      send_start();
      send_data(8'd3);
      send_data(8'h00);
      send_data(8'd5);
      send_data(8'hFF);
      send_data(ESCAPE);
      send_data(ESC_EOL);
      send_data(ESCAPE);
      send_data(8'd3);
      send_data(8'h5A);
      send_data(8'hA5);
      send_data(8'h80);
      send_data(8'hFF);
      send_delta(8'hFF, 8'hFF);
      send_data(8'hFF);
      send_data(8'h10);
      send_data(ESCAPE);
      send_data(ESC_EOP);
      send_data(8'h07);
      send_request(REQ_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_start();

      for (p = 0; p < PHASES; p++) begin
         idle_on  = (p < PHASES - 1) && (p != 2);
         stall_on = (p < PHASES - 1) && (p != 3);
         case (p)
            0: set_size(11'd1, 11'd1);
            1: set_size(11'd1024, 11'd1024);
            2: set_size(11'd2047, 11'd2047);
            3: set_size(11'd16, 11'd8);
            4: set_size(11'($urandom_range(1, 64)), 11'($urandom_range(1, 32)));
            default: set_size(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
         endcase
         send_start();
         target   = requests_sent + RANDOM_REQUESTS / PHASES;
         mid      = requests_sent + 50;
         mid_done = 1'b0;
         while (requests_sent < target) begin
            if (!mid_done && requests_sent >= mid) begin
               mid_done = 1'b1;
               if (p == 1)
                  long_hold = 1'b1;
               else if (p == 2)
                  wait_idle();
            end
            send_rle_chunk();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("Ran %0d requests over %0d image sizes: runs, literals, deltas, restarts.",
               requests_sent, settings_used);
      $display("Fills checked: %0d drawn, %0d out of range, %0d picture ends.",
               fill_count, error_count, done_count);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
rtl/bmprle_pkg.sv
rtl/bmprle_if.sv
rtl/bmp_rle8_pixel_decoder.sv
tb/bmprle_fill_checker.sv
tb/tb_top.sv
